### hdl/wfba_pkg.sv
// shared constants for the worst-fit block allocator
`default_nettype none
package wfba_pkg;
  localparam int MAX_BLOCKS_DEF     = 64;
  localparam int HEADER_BYTES_DEF   = 32;
  localparam int FOOTER_BYTES_DEF   = 8;
  localparam int POOL_MAX_BYTES_DEF = 65536;
  localparam int SIZE_W = 17;
  localparam int OFF_W  = 16;
  localparam logic [SIZE_W-1:0] FIELD_MAX = 17'h1FFFF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_BADPTR  = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
endpackage
`default_nettype wire

### hdl/wfba_core.sv
// block table memory with scan, shift and summary sequencer
`default_nettype none
module wfba_core
  import wfba_pkg::*;
#(
  parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
  parameter int FOOTER_BYTES   = FOOTER_BYTES_DEF,
  parameter int POOL_MAX_BYTES = POOL_MAX_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_pool,
  input  wire logic              start,
  input  wire logic              func,
  input  wire logic [SIZE_W-1:0] req_size,
  input  wire logic [OFF_W-1:0]  off,
  output logic                   busy,
  output logic                   done,
  output logic [1:0]             status,
  output logic [OFF_W-1:0]       result_offset,
  output logic [SIZE_W-1:0]      largest_free,
  output logic [SIZE_W-1:0]      total_free
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = 24;
  localparam int SPLIT_FLOOR = HEADER_BYTES + 1 + FOOTER_BYTES;
  localparam logic [AW-1:0] HF = AW'(HEADER_BYTES + FOOTER_BYTES);
  localparam logic [AW-1:0] HB = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] MINS = AW'(SPLIT_FLOOR);
  localparam logic [AW-1:0] PMAX = AW'(POOL_MAX_BYTES < 65536 ? POOL_MAX_BYTES : 65536);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SCAN   = 5'd1;   // issue read at idx
  localparam logic [4:0] S_SCANW  = 5'd2;   // evaluate read data
  localparam logic [4:0] S_DEC    = 5'd3;
  localparam logic [4:0] S_INS    = 5'd4;   // shift up: read below or place new entry
  localparam logic [4:0] S_INSW   = 5'd5;
  localparam logic [4:0] S_RCHK   = 5'd6;   // read right neighbor
  localparam logic [4:0] S_RCHKW  = 5'd7;
  localparam logic [4:0] S_LCHK   = 5'd8;   // read left neighbor
  localparam logic [4:0] S_LCHKW  = 5'd9;
  localparam logic [4:0] S_MERGE  = 5'd10;  // write the merged free block
  localparam logic [4:0] S_DROP   = 5'd11;  // shift down over merged entries
  localparam logic [4:0] S_DROPW  = 5'd12;
  localparam logic [4:0] S_SUM    = 5'd13;
  localparam logic [4:0] S_SUMR   = 5'd14;
  localparam logic [4:0] S_SUMW   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  // memory entry: start, payload, free
  logic [OFF_W-1:0]  mem_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] mem_pay   [MAX_BLOCKS];
  logic              mem_free  [MAX_BLOCKS];
  logic [OFF_W-1:0]  rd_start;
  logic [SIZE_W-1:0] rd_pay;
  logic              rd_free;
  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [OFF_W-1:0]  wstart;
  logic [SIZE_W-1:0] wpay;
  logic              wfree;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_pay[waddr]   <= wpay;
      mem_free[waddr]  <= wfree;
    end
    rd_start <= mem_start[raddr];
    rd_pay   <= mem_pay[raddr];
    rd_free  <= mem_free[raddr];
  end

  logic [4:0]        state;
  logic [CW-1:0]     count, idx;
  logic              op, found, rmerge, lmerge;
  logic [IW-1:0]     best, dst;
  logic [SIZE_W-1:0] best_pay, req, acc_pay, left_pay;
  logic [OFF_W-1:0]  best_start, offr, left_start;
  logic [AW-1:0]     larg, tot;
  logic [1:0]        st;
  logic [OFF_W-1:0]  res;
  logic [AW-1:0]     left;
  logic [AW-1:0]     cfg_clip;
  logic [SIZE_W-1:0] init_pay;
  logic              do_split, ins_last;
  logic [OFF_W-1:0]  split_start;
  logic [SIZE_W-1:0] split_pay;
  logic [CW-1:0]     drop_n, merge_dst;

  assign busy = (state != S_IDLE);
  assign left = AW'(best_pay) - AW'(req);
  assign cfg_clip = (AW'(cfg_pool) < MINS) ? MINS :
                    ((AW'(cfg_pool) > PMAX) ? PMAX : AW'(cfg_pool));
  assign init_pay = SIZE_W'((rst ? PMAX : cfg_clip) - HF);
  assign do_split = (left >= MINS) && (count < CNT_MAX);
  assign ins_last = (idx == CW'(best) + CW'(1));
  assign split_start = OFF_W'(AW'(best_start) + HF + AW'(req));
  assign split_pay = SIZE_W'(left - HF);
  assign drop_n = CW'(rmerge) + CW'(lmerge);
  assign merge_dst = lmerge ? CW'(best) : CW'(best) + CW'(1);

  // single read and write port of the block table
  always_comb begin
    raddr  = idx[IW-1:0];
    we     = 1'b0;
    waddr  = best;
    wstart = best_start;
    wpay   = acc_pay;
    wfree  = 1'b1;
    if (rst || cfg_we) begin
      we     = 1'b1;
      waddr  = '0;
      wstart = '0;
      wpay   = init_pay;
    end else begin
      case (state)
        S_DEC: begin
          if (op == FUNC_ALLOC && found && best_pay >= req) begin
            we    = 1'b1;
            wfree = 1'b0;
            wpay  = do_split ? req : best_pay;
          end
        end
        S_INS: begin
          if (ins_last) begin
            we     = 1'b1;
            waddr  = idx[IW-1:0];
            wstart = split_start;
            wpay   = split_pay;
          end else begin
            raddr = idx[IW-1:0] - IW'(1);
          end
        end
        S_INSW: begin
          we     = 1'b1;
          waddr  = idx[IW-1:0];
          wstart = rd_start;
          wpay   = rd_pay;
          wfree  = rd_free;
        end
        S_RCHK: raddr = best + IW'(1);
        S_LCHK: raddr = best - IW'(1);
        S_MERGE: begin
          we = 1'b1;
          if (lmerge) begin
            // left neighbor absorbs this block
            waddr  = best - IW'(1);
            wstart = left_start;
            wpay   = SIZE_W'(AW'(left_pay) + HF + AW'(acc_pay));
          end
        end
        S_DROPW: begin
          we     = 1'b1;
          waddr  = dst;
          wstart = rd_start;
          wpay   = rd_pay;
          wfree  = rd_free;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst || cfg_we) begin
      state <= S_IDLE;
      count <= CW'(1);
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= func; req <= req_size; offr <= off;
            found <= 1'b0; idx <= '0; best <= '0;
            best_pay <= '0; best_start <= '0;
            rmerge <= 1'b0; lmerge <= 1'b0;
            st <= ST_OK; res <= '0;
            if (func == FUNC_ALLOC && req_size == '0) begin
              st <= ST_ZERO;
              state <= S_SUM;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: state <= S_SCANW;
        S_SCANW: begin
          // one entry compared per pass through the shared comparator
          if (op == FUNC_ALLOC) begin
            if (rd_free && (!found || rd_pay >= best_pay)) begin
              found <= 1'b1; best <= idx[IW-1:0];
              best_pay <= rd_pay; best_start <= rd_start;
            end
          end else if (!found && !rd_free && (AW'(rd_start) + HB) == AW'(offr)) begin
            found <= 1'b1; best <= idx[IW-1:0];
            best_pay <= rd_pay; best_start <= rd_start;
          end
          if (idx + CW'(1) >= count) state <= S_DEC;
          else begin
            idx <= idx + CW'(1);
            state <= S_SCAN;
          end
        end
        S_DEC: begin
          if (op == FUNC_ALLOC) begin
            if (!found || best_pay < req) begin
              st <= ST_NOFIT; state <= S_SUM;
            end else begin
              res <= OFF_W'(AW'(best_start) + HB);
              if (do_split) begin
                // open a slot at best+1 by shifting entries up
                idx <= count;
                state <= S_INS;
              end else begin
                state <= S_SUM;
              end
            end
          end else if (!found) begin
            st <= ST_BADPTR; state <= S_SUM;
          end else begin
            acc_pay <= best_pay;
            state <= S_RCHK;
          end
        end
        S_INS: begin
          if (ins_last) begin
            count <= count + CW'(1);
            state <= S_SUM;
          end else begin
            state <= S_INSW;
          end
        end
        S_INSW: begin
          idx <= idx - CW'(1);
          state <= S_INS;
        end
        S_RCHK: state <= (CW'(best) + CW'(1) < count) ? S_RCHKW : S_LCHK;
        S_RCHKW: begin
          if (rd_free) begin
            rmerge <= 1'b1;
            acc_pay <= SIZE_W'(AW'(best_pay) + HF + AW'(rd_pay));
          end
          state <= S_LCHK;
        end
        S_LCHK: state <= (best != '0) ? S_LCHKW : S_MERGE;
        S_LCHKW: begin
          if (rd_free) begin
            lmerge <= 1'b1;
            left_start <= rd_start;
            left_pay <= rd_pay;
          end
          state <= S_MERGE;
        end
        S_MERGE: begin
          dst <= merge_dst[IW-1:0];
          idx <= merge_dst + drop_n;
          state <= (drop_n == '0) ? S_SUM : S_DROP;
        end
        S_DROP: begin
          if (idx >= count) begin
            count <= count - drop_n;
            state <= S_SUM;
          end else begin
            state <= S_DROPW;
          end
        end
        S_DROPW: begin
          dst <= dst + IW'(1);
          idx <= idx + CW'(1);
          state <= S_DROP;
        end
        S_SUM: begin
          idx <= '0; larg <= '0; tot <= '0;
          state <= S_SUMR;
        end
        S_SUMR: state <= S_SUMW;
        S_SUMW: begin
          if (rd_free) begin
            if (AW'(rd_pay) > larg) larg <= AW'(rd_pay);
            tot <= tot + AW'(rd_pay);
          end
          if (idx + CW'(1) >= count) state <= S_DONE;
          else begin
            idx <= idx + CW'(1);
            state <= S_SUMR;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          status <= st;
          result_offset <= res;
          largest_free <= (larg > AW'(FIELD_MAX)) ? FIELD_MAX : SIZE_W'(larg);
          total_free <= (tot > AW'(FIELD_MAX)) ? FIELD_MAX : SIZE_W'(tot);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/worst_fit_block_allocator_unit.sv
// top level of the worst-fit block allocator
// usage: requests enter on s_axis (tdata: func, req_size, payload_offset),
// one result per request leaves on m_axis (status, result_offset,
// largest_free, total_free). pool_we/pool_data write the pool size and
// rebuild the pool as one free block; write it only while idle.
// an item scans the N-entry block table one entry at a time through the
// single read port, shifts S entries on split or merge, then sums free
// space over the table before m_axis_tvalid rises. a zero-size request
// skips the scan.
// the block accepts one item at a time; s_axis_tready is low while busy
// and while a result waits in the output register.
// reset rebuilds the pool at its maximum size with one free block.
// a stalled receiver holds the result and blocks further input.
`default_nettype none
module worst_fit_block_allocator_unit
  import wfba_pkg::*;
#(
  parameter int MAX_BLOCKS     = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
  parameter int FOOTER_BYTES   = FOOTER_BYTES_DEF,
  parameter int POOL_MAX_BYTES = POOL_MAX_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pool_we,
  input  wire logic [16:0] pool_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // func, req_size, payload_offset
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // status, result_offset, largest_free, total_free
);
  logic busy, done;
  logic [1:0] status;
  logic [OFF_W-1:0] result_offset;
  logic [SIZE_W-1:0] largest_free, total_free;
  logic start;

  // done covers the cycle before the result register fills
  assign s_axis_tready = !busy && !done && !m_axis_tvalid;
  assign start = s_axis_tvalid && s_axis_tready;

  wfba_core #(
    .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES),
    .FOOTER_BYTES(FOOTER_BYTES), .POOL_MAX_BYTES(POOL_MAX_BYTES)
  ) u_core (
    .clk(clk), .rst(rst), .cfg_we(pool_we), .cfg_pool(pool_data),
    .start(start), .func(s_axis_tdata[0]), .req_size(s_axis_tdata[17:1]),
    .off(s_axis_tdata[33:18]), .busy(busy), .done(done), .status(status),
    .result_offset(result_offset), .largest_free(largest_free),
    .total_free(total_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assign m_axis_tdata = {4'd0, total_free, largest_free, result_offset, status};
endmodule
`default_nettype wire
